>>> hdl/rss_pkg.sv
// Shared types and constants for the redundant server selector.
package rss_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  // Input item modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_UPDATED  = 2'd0;
  localparam logic [1:0] STAT_SELECTED = 2'd1;
  localparam logic [1:0] STAT_NONE     = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SPREAD_DISK = 1'b0;
  localparam logic CFG_SPREAD_LOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TIE,
    ST_SCAN_USED,
    ST_SCAN_OK,
    ST_DIV_GRP,
    ST_FIND_GRP,
    ST_PICK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        readonly;
    logic        up;
    logic [7:0]  priority_v;
    logic [7:0]  group_v;
    logic [31:0] free_kb;
    logic [15:0] load;
  } slot_entry_t;

endpackage

>>> hdl/redundant_server_selector_unit.sv
// Redundant server selector: slot table, sequencer and shared remainder unit.
//
//  channel | direction | handshake               | beat contents
//  --------+-----------+-------------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready     | mode, entry fields, rand_group, rand_tie
//  out_    | output    | out_valid / out_ready   | status, chosen index, group, priority
//  cfg_    | input     | cfg_write_en (no wait)  | cfg_index selects spread_disk/spread_load
//
// A write, clear or unused-mode beat goes from the accept step straight to the finish
// step, which loads the output register. A select runs from the accept step through
// two passes of the shared restoring remainder unit over the 16-bit dividend (rand_tie
// mod NUM_SLOTS, rand_group mod group count), three walks over the slot memory at one
// read per cycle, each ending once its last read has left the registered read port, a
// scan over the 256-group bitmap, 8 groups a step, and the output load.
// With no eligible group the select ends after the second walk.
// Reset clears the valid and used marks and both spread registers; there is no
// clearing pass. in_ready is high only while idle; a finished result waits in the
// output register, and the finish step waits while it is full and out_ready is low.
module redundant_server_selector_unit #(
  parameter int NUM_SLOTS = rss_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic        cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_entry_index,
  input  logic [7:0]  in_entry_group,
  input  logic [7:0]  in_entry_priority,
  input  logic        in_entry_up,
  input  logic        in_entry_readonly,
  input  logic [31:0] in_entry_free_kb,
  input  logic [15:0] in_entry_load,
  input  logic [15:0] in_rand_group,
  input  logic [15:0] in_rand_tie,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_chosen_index,
  output logic [7:0]  out_chosen_group,
  output logic [7:0]  out_chosen_priority
);

  localparam int SW = $clog2(NUM_SLOTS);   // slot index width
  localparam int CW = SW + 1;              // walk counter, holds NUM_SLOTS itself

  // ---------------------------------------------------------------- registers
  rss_pkg::state_t       state_r, state_nxt;
  logic                  spread_disk_r, spread_disk_nxt;
  logic                  spread_load_r, spread_load_nxt;
  logic [NUM_SLOTS-1:0]  slot_valid_r, slot_valid_nxt;
  logic [NUM_SLOTS-1:0]  slot_used_r, slot_used_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  rd_vld_r, rd_vld_nxt;

  logic [255:0]          used_grp_r, used_grp_nxt;
  logic [255:0]          ok_grp_r, ok_grp_nxt;
  logic [8:0]            count_r, count_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [SW-1:0]         addr_r, addr_nxt;
  logic [15:0]           rg_r, rg_nxt;
  logic [SW-1:0]         start_r, start_nxt;
  logic [7:0]            pick_r, pick_nxt;
  logic [8:0]            n_r, n_nxt;
  logic [4:0]            chunk_r, chunk_nxt;
  logic [7:0]            sel_grp_r, sel_grp_nxt;
  logic                  have_r, have_nxt;
  logic [SW-1:0]         best_idx_r, best_idx_nxt;
  logic [7:0]            best_grp_r, best_grp_nxt;
  logic [7:0]            best_prio_r, best_prio_nxt;
  logic [31:0]           best_free_r, best_free_nxt;
  logic [15:0]           best_load_r, best_load_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [15:0]           div_num_r, div_num_nxt;
  logic [8:0]            div_den_r, div_den_nxt;
  logic [8:0]            div_rem_r, div_rem_nxt;
  logic [3:0]            div_cnt_r, div_cnt_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [3:0]            out_idx_r, out_idx_nxt;
  logic [7:0]            out_grp_r, out_grp_nxt;
  logic [7:0]            out_prio_r, out_prio_nxt;

  // slot memory and its registered read port
  rss_pkg::slot_entry_t  slot_mem [NUM_SLOTS];
  rss_pkg::slot_entry_t  rd_data_r;
  logic                  rd_valid_bit_r;
  logic                  rd_used_bit_r;
  logic [SW-1:0]         rd_idx_r;

  // ---------------------------------------------------------------- comb signals
  logic                  in_fire;
  logic                  mem_we;
  logic [SW-1:0]         wr_addr;
  rss_pkg::slot_entry_t  wr_entry;
  logic                  pass_state;
  logic                  issuing;
  logic                  pass_done;
  logic                  rd_elig;
  logic [9:0]            div_shift;
  logic                  div_ge;
  logic [8:0]            div_rem_step;
  logic [7:0]            chunk_bits;
  logic [3:0]            chunk_pc;
  logic                  chunk_hit;
  logic [8:0]            chunk_k;
  logic [3:0]            run_cnt;
  logic [2:0]            sel_bit;
  logic                  sel_found;
  logic                  rd_better;

  assign in_ready            = (state_r == rss_pkg::ST_IDLE);
  assign in_fire             = in_valid && in_ready;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chosen_index    = out_idx_r;
  assign out_chosen_group    = out_grp_r;
  assign out_chosen_priority = out_prio_r;

  // Writes beyond the table are dropped.
  assign wr_addr  = SW'(in_entry_index);
  assign mem_we   = in_fire && (in_mode == rss_pkg::MODE_WRITE) &&
                    (32'(in_entry_index) < NUM_SLOTS);
  assign wr_entry = '{readonly:   in_entry_readonly,
                      up:         in_entry_up,
                      priority_v: in_entry_priority,
                      group_v:    in_entry_group,
                      free_kb:    in_entry_free_kb,
                      load:       in_entry_load};

  // Slot walk: issue one read per cycle, consume it in the next cycle.
  assign pass_state = (state_r == rss_pkg::ST_SCAN_USED) ||
                      (state_r == rss_pkg::ST_SCAN_OK) ||
                      (state_r == rss_pkg::ST_PICK);
  assign issuing    = pass_state && (cnt_r < CW'(NUM_SLOTS));
  assign pass_done  = (cnt_r == CW'(NUM_SLOTS)) && !rd_vld_r;
  assign rd_elig    = rd_valid_bit_r && rd_data_r.up && !rd_data_r.readonly;

  // Shared restoring remainder step: one quotient bit per cycle.
  assign div_shift    = {div_rem_r, div_num_r[15]};
  assign div_ge       = div_shift >= {1'b0, div_den_r};
  assign div_rem_step = div_ge ? 9'(div_shift - {1'b0, div_den_r}) : div_shift[8:0];

  // Group bitmap scan, eight groups per step.
  assign chunk_bits = ok_grp_r[{chunk_r, 3'b000} +: 8];

  always_comb begin
    chunk_pc = '0;
    for (int i = 0; i < 8; i++) begin
      chunk_pc = chunk_pc + 4'(chunk_bits[i]);
    end
  end

  assign chunk_hit = 9'(n_r + 9'(chunk_pc)) > {1'b0, pick_r};
  assign chunk_k   = {1'b0, pick_r} - n_r;

  // Locate the chunk_k-th set bit of the chunk.
  always_comb begin
    run_cnt   = '0;
    sel_bit   = '0;
    sel_found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (chunk_bits[i] && !sel_found && (9'(run_cnt) == chunk_k)) begin
        sel_bit   = 3'(i);
        sel_found = 1'b1;
      end
      if (chunk_bits[i]) begin
        run_cnt = run_cnt + 4'd1;
      end
    end
  end

  // Lexicographic preference: lower priority, then free space and load where enabled.
  always_comb begin
    if (rd_data_r.priority_v != best_prio_r) begin
      rd_better = rd_data_r.priority_v < best_prio_r;
    end else if (spread_disk_r && (rd_data_r.free_kb != best_free_r)) begin
      rd_better = rd_data_r.free_kb > best_free_r;
    end else if (spread_load_r && (rd_data_r.load != best_load_r)) begin
      rd_better = rd_data_r.load < best_load_r;
    end else begin
      rd_better = 1'b0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt       = state_r;
    spread_disk_nxt = spread_disk_r;
    spread_load_nxt = spread_load_r;
    slot_valid_nxt  = slot_valid_r;
    slot_used_nxt   = slot_used_r;
    out_valid_nxt   = out_valid_r;
    rd_vld_nxt      = issuing;
    used_grp_nxt    = used_grp_r;
    ok_grp_nxt      = ok_grp_r;
    count_nxt       = count_r;
    cnt_nxt         = cnt_r;
    addr_nxt        = addr_r;
    rg_nxt          = rg_r;
    start_nxt       = start_r;
    pick_nxt        = pick_r;
    n_nxt           = n_r;
    chunk_nxt       = chunk_r;
    sel_grp_nxt     = sel_grp_r;
    have_nxt        = have_r;
    best_idx_nxt    = best_idx_r;
    best_grp_nxt    = best_grp_r;
    best_prio_nxt   = best_prio_r;
    best_free_nxt   = best_free_r;
    best_load_nxt   = best_load_r;
    res_status_nxt  = res_status_r;
    div_num_nxt     = div_num_r;
    div_den_nxt     = div_den_r;
    div_rem_nxt     = div_rem_r;
    div_cnt_nxt     = div_cnt_r;
    out_status_nxt  = out_status_r;
    out_idx_nxt     = out_idx_r;
    out_grp_nxt     = out_grp_r;
    out_prio_nxt    = out_prio_r;

    if (cfg_write_en) begin
      case (cfg_index)
        rss_pkg::CFG_SPREAD_DISK: spread_disk_nxt = cfg_data;
        rss_pkg::CFG_SPREAD_LOAD: spread_load_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (issuing) begin
      cnt_nxt  = cnt_r + CW'(1);
      addr_nxt = (addr_r == SW'(NUM_SLOTS - 1)) ? '0 : addr_r + SW'(1);
    end

    case (state_r)
      rss_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = rss_pkg::STAT_UPDATED;
          state_nxt      = rss_pkg::ST_FINISH;
          case (in_mode)
            rss_pkg::MODE_WRITE: begin
              if (mem_we) begin
                slot_valid_nxt[wr_addr] = 1'b1;
                slot_used_nxt[wr_addr]  = 1'b0;
              end
            end
            rss_pkg::MODE_CLEAR: begin
              slot_valid_nxt = '0;
              slot_used_nxt  = '0;
            end
            rss_pkg::MODE_SELECT: begin
              used_grp_nxt = '0;
              ok_grp_nxt   = '0;
              count_nxt    = '0;
              rg_nxt       = in_rand_group;
              div_num_nxt  = in_rand_tie;
              div_den_nxt  = 9'(NUM_SLOTS);
              div_rem_nxt  = '0;
              div_cnt_nxt  = '0;
              state_nxt    = rss_pkg::ST_DIV_TIE;
            end
            default: ;
          endcase
        end
      end

      rss_pkg::ST_DIV_TIE: begin
        div_rem_nxt = div_rem_step;
        div_num_nxt = {div_num_r[14:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd15) begin
          start_nxt = SW'(div_rem_step);
          cnt_nxt   = '0;
          addr_nxt  = '0;
          state_nxt = rss_pkg::ST_SCAN_USED;
        end
      end

      rss_pkg::ST_SCAN_USED: begin
        // mark groups that already hold a used server
        if (rd_vld_r && rd_valid_bit_r && rd_used_bit_r) begin
          used_grp_nxt[rd_data_r.group_v] = 1'b1;
        end
        if (pass_done) begin
          cnt_nxt   = '0;
          addr_nxt  = '0;
          state_nxt = rss_pkg::ST_SCAN_OK;
        end
      end

      rss_pkg::ST_SCAN_OK: begin
        // collect eligible groups and count each the first time it shows up
        if (rd_vld_r && rd_elig && !used_grp_r[rd_data_r.group_v] &&
            !ok_grp_r[rd_data_r.group_v]) begin
          ok_grp_nxt[rd_data_r.group_v] = 1'b1;
          count_nxt = count_r + 9'd1;
        end
        if (pass_done) begin
          if (count_r == '0) begin
            res_status_nxt = rss_pkg::STAT_NONE;
            state_nxt      = rss_pkg::ST_FINISH;
          end else begin
            div_num_nxt = rg_r;
            div_den_nxt = count_r;
            div_rem_nxt = '0;
            div_cnt_nxt = '0;
            state_nxt   = rss_pkg::ST_DIV_GRP;
          end
        end
      end

      rss_pkg::ST_DIV_GRP: begin
        div_rem_nxt = div_rem_step;
        div_num_nxt = {div_num_r[14:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd15) begin
          pick_nxt  = 8'(div_rem_step);
          chunk_nxt = '0;
          n_nxt     = '0;
          state_nxt = rss_pkg::ST_FIND_GRP;
        end
      end

      rss_pkg::ST_FIND_GRP: begin
        if (chunk_hit) begin
          sel_grp_nxt = {chunk_r, sel_bit};
          cnt_nxt     = '0;
          addr_nxt    = start_r;
          have_nxt    = 1'b0;
          state_nxt   = rss_pkg::ST_PICK;
        end else if (chunk_r == 5'd31) begin
          res_status_nxt = rss_pkg::STAT_NONE;
          state_nxt      = rss_pkg::ST_FINISH;
        end else begin
          n_nxt     = 9'(n_r + 9'(chunk_pc));
          chunk_nxt = chunk_r + 5'd1;
        end
      end

      rss_pkg::ST_PICK: begin
        // walk circularly from the tie start, keep the strictly better entry
        if (rd_vld_r && rd_elig && (rd_data_r.group_v == sel_grp_r) &&
            (!have_r || rd_better)) begin
          have_nxt      = 1'b1;
          best_idx_nxt  = rd_idx_r;
          best_grp_nxt  = rd_data_r.group_v;
          best_prio_nxt = rd_data_r.priority_v;
          best_free_nxt = rd_data_r.free_kb;
          best_load_nxt = rd_data_r.load;
        end
        if (pass_done) begin
          if (have_r) begin
            slot_used_nxt[best_idx_r] = 1'b1;
            res_status_nxt = rss_pkg::STAT_SELECTED;
          end else begin
            res_status_nxt = rss_pkg::STAT_NONE;
          end
          state_nxt = rss_pkg::ST_FINISH;
        end
      end

      rss_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          if (res_status_r == rss_pkg::STAT_SELECTED) begin
            out_idx_nxt  = 4'(best_idx_r);
            out_grp_nxt  = best_grp_r;
            out_prio_nxt = best_prio_r;
          end else begin
            out_idx_nxt  = '0;
            out_grp_nxt  = '0;
            out_prio_nxt = '0;
          end
          state_nxt = rss_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rss_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rss_pkg::ST_IDLE;
      spread_disk_r <= 1'b0;
      spread_load_r <= 1'b0;
      slot_valid_r  <= '0;
      slot_used_r   <= '0;
      out_valid_r   <= 1'b0;
      rd_vld_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      spread_disk_r <= spread_disk_nxt;
      spread_load_r <= spread_load_nxt;
      slot_valid_r  <= slot_valid_nxt;
      slot_used_r   <= slot_used_nxt;
      out_valid_r   <= out_valid_nxt;
      rd_vld_r      <= rd_vld_nxt;
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    used_grp_r   <= used_grp_nxt;
    ok_grp_r     <= ok_grp_nxt;
    count_r      <= count_nxt;
    cnt_r        <= cnt_nxt;
    addr_r       <= addr_nxt;
    rg_r         <= rg_nxt;
    start_r      <= start_nxt;
    pick_r       <= pick_nxt;
    n_r          <= n_nxt;
    chunk_r      <= chunk_nxt;
    sel_grp_r    <= sel_grp_nxt;
    have_r       <= have_nxt;
    best_idx_r   <= best_idx_nxt;
    best_grp_r   <= best_grp_nxt;
    best_prio_r  <= best_prio_nxt;
    best_free_r  <= best_free_nxt;
    best_load_r  <= best_load_nxt;
    res_status_r <= res_status_nxt;
    div_num_r    <= div_num_nxt;
    div_den_r    <= div_den_nxt;
    div_rem_r    <= div_rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_grp_r    <= out_grp_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  // ---------------------------------------------------------------- slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_entry;
    end
    rd_data_r      <= slot_mem[addr_r];
    rd_valid_bit_r <= slot_valid_r[addr_r];
    rd_used_bit_r  <= slot_used_r[addr_r];
    rd_idx_r       <= addr_r;
  end

  // ---------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rss_pkg::ST_SCAN_OK) || (state_r == rss_pkg::ST_DIV_GRP) ||
     (state_r == rss_pkg::ST_FIND_GRP) || (state_r == rss_pkg::ST_PICK)) |->
    (count_r <= 9'(NUM_SLOTS)))
    else $error("eligible group count exceeds slot count");

  a_pick_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rss_pkg::ST_FIND_GRP) |-> ({1'b0, pick_r} < count_r))
    else $error("group pick not below group count");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rss_pkg::ST_DIV_TIE) || (state_r == rss_pkg::ST_DIV_GRP)) |->
    (div_rem_r < div_den_r))
    else $error("partial remainder not below divisor");

  a_chosen_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rss_pkg::ST_PICK) && pass_done && have_r) |=>
    (slot_used_r[$past(best_idx_r)] && slot_valid_r[$past(best_idx_r)]))
    else $error("chosen slot not marked used");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != rss_pkg::STAT_SELECTED)) |->
    ((out_idx_r == '0) && (out_grp_r == '0) && (out_prio_r == '0)))
    else $error("chosen fields nonzero without a selection");

endmodule

>>> tb/redundant_server_selector_unit_tb.sv
// Self-checking testbench for the redundant server selector: directed and random beats.
module redundant_server_selector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = rss_pkg::NUM_SLOTS_DEF;
  // Mode 3 has no name in the package; the block must answer it like a no-op write.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Room for the longest select, with receiver stalls on top.
  localparam int SELECT_CYCLES = 150;
  // Longest correct quiet stretch is the HOLD_CYCLES hold-off plus one select; take it
  // several times over.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_SETTING = 125;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  index;
    logic [7:0]  group;
    logic [7:0]  prio;
    logic        up;
    logic        readonly;
    logic [31:0] free_kb;
    logic [15:0] load;
    logic [15:0] rand_group;
    logic [15:0] rand_tie;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] index;
    logic [7:0] group;
    logic [7:0] prio;
  } pick_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic        cfg_index;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [3:0]  in_entry_index;
  logic [7:0]  in_entry_group;
  logic [7:0]  in_entry_priority;
  logic        in_entry_up;
  logic        in_entry_readonly;
  logic [31:0] in_entry_free_kb;
  logic [15:0] in_entry_load;
  logic [15:0] in_rand_group;
  logic [15:0] in_rand_tie;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [3:0]  out_chosen_index;
  logic [7:0]  out_chosen_group;
  logic [7:0]  out_chosen_priority;

  // Shadow copy of the server table and the spread registers.
  bit                   slot_live  [SLOTS];
  bit                   slot_taken [SLOTS];
  rss_pkg::slot_entry_t slot_info  [SLOTS];
  bit                   spread_disk_q;
  bit                   spread_load_q;

  pick_t pending_picks[$];
  int    fault_count = 0;
  int    offer_idle_pct = 0;
  int    sink_stall_pct = 0;
  int    hold_budget = 0;

  redundant_server_selector_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_entry_index      (in_entry_index),
    .in_entry_group      (in_entry_group),
    .in_entry_priority   (in_entry_priority),
    .in_entry_up         (in_entry_up),
    .in_entry_readonly   (in_entry_readonly),
    .in_entry_free_kb    (in_entry_free_kb),
    .in_entry_load       (in_entry_load),
    .in_rand_group       (in_rand_group),
    .in_rand_tie         (in_rand_tie),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_chosen_index    (out_chosen_index),
    .out_chosen_group    (out_chosen_group),
    .out_chosen_priority (out_chosen_priority)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit servable(int s);
    return slot_live[s] && slot_info[s].up && !slot_info[s].readonly;
  endfunction

  // True when slot a strictly beats slot b: lower priority first, then the
  // enabled spread keys in order (more free space, then lower load).
  function automatic bit outranks(int a, int b);
    if (slot_info[a].priority_v != slot_info[b].priority_v)
      return slot_info[a].priority_v < slot_info[b].priority_v;
    if (spread_disk_q && slot_info[a].free_kb != slot_info[b].free_kb)
      return slot_info[a].free_kb > slot_info[b].free_kb;
    if (spread_load_q && slot_info[a].load != slot_info[b].load)
      return slot_info[a].load < slot_info[b].load;
    return 1'b0;
  endfunction

  // Apply one accepted beat to the shadow table and return the result it must produce.
  function automatic pick_t predict_pick(request_t r);
    pick_t res;
    bit    grp_busy [256];
    bit    grp_open [256];
    int    open_count;
    int    target;
    int    rank;
    int    first;
    int    best;
    int    s;
    bit    found;
    res = '0;
    res.status = rss_pkg::STAT_UPDATED;
    case (r.mode)
      rss_pkg::MODE_WRITE: begin
        // Every 4-bit index is inside a 16-slot table; a rewrite also frees the slot.
        slot_live[r.index]  = 1'b1;
        slot_taken[r.index] = 1'b0;
        slot_info[r.index]  = '{readonly: r.readonly, up: r.up, priority_v: r.prio,
                                group_v: r.group, free_kb: r.free_kb, load: r.load};
      end
      rss_pkg::MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_live[i]  = 1'b0;
          slot_taken[i] = 1'b0;
        end
      end
      rss_pkg::MODE_SELECT: begin
        for (int g = 0; g < 256; g++) begin
          grp_busy[g] = 1'b0;
          grp_open[g] = 1'b0;
        end
        // A group with any used server is out of the running.
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && slot_taken[i]) grp_busy[slot_info[i].group_v] = 1'b1;
        for (int i = 0; i < SLOTS; i++)
          if (servable(i) && !grp_busy[slot_info[i].group_v])
            grp_open[slot_info[i].group_v] = 1'b1;
        open_count = 0;
        for (int g = 0; g < 256; g++)
          if (grp_open[g]) open_count++;
        if (open_count == 0) begin
          res.status = rss_pkg::STAT_NONE;
        end else begin
          // Take the open group of rank rand_group mod count, ascending.
          target = -1;
          rank = 0;
          for (int g = 0; g < 256; g++) begin
            if (grp_open[g]) begin
              if (rank == int'(r.rand_group) % open_count) target = g;
              rank++;
            end
          end
          // Walk circularly from the tie offset; the first best slot wins.
          first = int'(r.rand_tie) % SLOTS;
          found = 1'b0;
          best = 0;
          for (int j = 0; j < SLOTS; j++) begin
            s = (first + j) % SLOTS;
            if (servable(s) && int'(slot_info[s].group_v) == target) begin
              if (!found || outranks(s, best)) begin
                best = s;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            res.status = rss_pkg::STAT_NONE;
          end else begin
            slot_taken[best] = 1'b1;
            res.status = rss_pkg::STAT_SELECTED;
            res.index  = best[3:0];
            res.group  = slot_info[best].group_v;
            res.prio   = slot_info[best].priority_v;
          end
        end
      end
      default: begin
        // Spare mode: no change to the table.
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  function automatic request_t write_req(logic [3:0] idx, logic [7:0] grp, logic [7:0] prio,
                                         logic up, logic ro, logic [31:0] kb,
                                         logic [15:0] ld);
    request_t r;
    r = '0;
    r.mode     = rss_pkg::MODE_WRITE;
    r.index    = idx;
    r.group    = grp;
    r.prio     = prio;
    r.up       = up;
    r.readonly = ro;
    r.free_kb  = kb;
    r.load     = ld;
    return r;
  endfunction

  function automatic request_t select_req(logic [15:0] rg, logic [15:0] rt);
    request_t r;
    r = '0;
    r.mode       = rss_pkg::MODE_SELECT;
    r.rand_group = rg;
    r.rand_tie   = rt;
    return r;
  endfunction

  function automatic request_t mode_req(logic [1:0] m);
    request_t r;
    r = '0;
    r.mode = m;
    return r;
  endfunction

  // Random beat: few groups and priorities and pooled free/load values so that groups
  // hold several servers and ties are common; full-range values now and then.
  function automatic request_t random_req();
    request_t r;
    int       roll;
    r.index    = 4'($urandom_range(15));
    r.group    = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    r.prio     = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.up       = ($urandom_range(99) < 85);
    r.readonly = ($urandom_range(99) < 15);
    case ($urandom_range(3))
      0:       r.free_kb = 32'd0;
      1:       r.free_kb = 32'hFFFF_FFFF;
      2:       r.free_kb = 32'd4096;
      default: r.free_kb = $urandom;
    endcase
    case ($urandom_range(3))
      0:       r.load = 16'd0;
      1:       r.load = 16'hFFFF;
      2:       r.load = 16'd40;
      default: r.load = 16'($urandom);
    endcase
    r.rand_group = 16'($urandom);
    r.rand_tie   = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 50)      r.mode = rss_pkg::MODE_WRITE;
    else if (roll < 96) r.mode = rss_pkg::MODE_SELECT;
    else if (roll < 98) r.mode = rss_pkg::MODE_CLEAR;
    else                r.mode = MODE_SPARE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until accepted; record its expected result on
  // acceptance. in_valid stays high on return so a back-to-back beat drops it only for an idle gap.
  task automatic offer_request(request_t r);
    if (offer_idle_pct > 0 && $urandom_range(99) < offer_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < offer_idle_pct);
    end
    in_valid          <= 1'b1;
    in_mode           <= r.mode;
    in_entry_index    <= r.index;
    in_entry_group    <= r.group;
    in_entry_priority <= r.prio;
    in_entry_up       <= r.up;
    in_entry_readonly <= r.readonly;
    in_entry_free_kb  <= r.free_kb;
    in_entry_load     <= r.load;
    in_rand_group     <= r.rand_group;
    in_rand_tie       <= r.rand_tie;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_picks.insert(pending_picks.size(), predict_pick(r));
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  // Write both spread registers; call only with the block idle.
  task automatic set_spread(bit disk, bit ld);
    cfg_write_en <= 1'b1;
    cfg_index    <= rss_pkg::CFG_SPREAD_DISK;
    cfg_data     <= disk;
    @(posedge clk);
    spread_disk_q = disk;
    cfg_index <= rss_pkg::CFG_SPREAD_LOAD;
    cfg_data  <= ld;
    @(posedge clk);
    spread_load_q = ld;
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Select on an empty table reports no server; the spare mode is a plain update.
  task automatic test_empty_and_spare();
    offer_request(select_req(16'h0000, 16'h0000));
    offer_request(mode_req(MODE_SPARE));
  endtask

  // Field extremes, down and read-only servers skipped, a used group shut out,
  // and a rewrite that frees a used slot again.
  task automatic test_extremes_and_reuse();
    offer_request(write_req(4'd0, 8'hFF, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    offer_request(write_req(4'd15, 8'h00, 8'h00, 1'b1, 1'b0, 32'd0, 16'd0));
    offer_request(write_req(4'd5, 8'h00, 8'h00, 1'b0, 1'b0, 32'd7, 16'd7));
    offer_request(write_req(4'd6, 8'h00, 8'h00, 1'b1, 1'b1, 32'd7, 16'd7));
    offer_request(select_req(16'h0000, 16'hFFFF));
    offer_request(select_req(16'hFFFF, 16'h0000));
    offer_request(select_req(16'h1234, 16'h0005));
    offer_request(write_req(4'd15, 8'h00, 8'h00, 1'b1, 1'b0, 32'd0, 16'd0));
    offer_request(select_req(16'hFFFF, 16'hFFFF));
  endtask

  // Full ties inside one group fall to the first slot at or after the tie offset,
  // wrapping past the top of the table.
  task automatic test_tie_rotation();
    offer_request(mode_req(rss_pkg::MODE_CLEAR));
    offer_request(write_req(4'd3, 8'd7, 8'd4, 1'b1, 1'b0, 32'd50, 16'd9));
    offer_request(write_req(4'd9, 8'd7, 8'd4, 1'b1, 1'b0, 32'd50, 16'd9));
    offer_request(write_req(4'd12, 8'd7, 8'd4, 1'b1, 1'b0, 32'd50, 16'd9));
    offer_request(select_req(16'h0000, 16'd10));
    offer_request(write_req(4'd12, 8'd7, 8'd4, 1'b1, 1'b0, 32'd50, 16'd9));
    offer_request(select_req(16'h0000, 16'hFFFF));
  endtask

  // With both spread keys on, free space decides first and load breaks what is left.
  task automatic test_spread_order();
    settle_outputs();
    set_spread(1'b1, 1'b1);
    offer_request(write_req(4'd9, 8'd7, 8'd4, 1'b1, 1'b0, 32'd100, 16'd5));
    offer_request(write_req(4'd3, 8'd7, 8'd4, 1'b1, 1'b0, 32'd100, 16'd2));
    offer_request(select_req(16'h0000, 16'd9));
  endtask

  // Random beats under every spread setting, with the given idle rates.
  task automatic test_random_phase(int gap_pct, int stall_pct);
    for (int setting = 0; setting < 4; setting++) begin
      settle_outputs();
      set_spread(setting[0], setting[1]);
      offer_idle_pct = gap_pct;
      sink_stall_pct = stall_pct;
      repeat (RANDOM_PER_SETTING) offer_request(random_req());
    end
  endtask

  // Hold the result channel off for a long stretch while beats keep coming, so the
  // block fills and stalls its input.
  task automatic test_backpressure();
    settle_outputs();
    offer_idle_pct = 0;
    sink_stall_pct = 0;
    hold_budget <= HOLD_CYCLES;
    repeat (40) offer_request(random_req());
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest expectation, then drive ready
  // ---------------------------------------------------------------------------

  initial begin
    pick_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (pending_picks.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected result beat: status %0d index %0d group %0d prio %0d",
                     out_status, out_chosen_index, out_chosen_group, out_chosen_priority);
          fault_count++;
        end else begin
          want = pending_picks.pop_front();
          if (out_status !== want.status || out_chosen_index !== want.index ||
              out_chosen_group !== want.group || out_chosen_priority !== want.prio) begin
            if (fault_count < 10)
              $display("result mismatch: exp status %0d index %0d group %0d prio %0d,",
                       want.status, want.index, want.group, want.prio,
                       " got status %0d index %0d group %0d prio %0d",
                       out_status, out_chosen_index, out_chosen_group,
                       out_chosen_priority);
            fault_count++;
          end
        end
      end
      // Count the long hold-off down here; otherwise stall at the phase's rate.
      if (hold_budget > 0) begin
        out_ready   <= 1'b0;
        hold_budget <= hold_budget - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("redundant_server_selector_unit_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             <= 1'b0;
    cfg_write_en      <= 1'b0;
    cfg_index         <= rss_pkg::CFG_SPREAD_DISK;
    cfg_data          <= 1'b0;
    in_valid          <= 1'b0;
    in_mode           <= rss_pkg::MODE_WRITE;
    in_entry_index    <= '0;
    in_entry_group    <= '0;
    in_entry_priority <= '0;
    in_entry_up       <= 1'b0;
    in_entry_readonly <= 1'b0;
    in_entry_free_kb  <= '0;
    in_entry_load     <= '0;
    in_rand_group     <= '0;
    in_rand_tie       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_spare();
    test_extremes_and_reuse();
    test_tie_rotation();
    test_spread_order();
    test_random_phase(15, 52);
    test_backpressure();
    test_random_phase(52, 15);
    test_random_phase(0, 0);

    // Drain, then give a late or extra beat time to show up.
    settle_outputs();
    repeat (SELECT_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_picks.size() == 0) begin
      $display("redundant_server_selector_unit_tb: clean");
    end else begin
      $display("redundant_server_selector_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> redundant_server_selector_unit.f
hdl/rss_pkg.sv
hdl/redundant_server_selector_unit.sv
tb/redundant_server_selector_unit_tb.sv
